// ===== hdl/terminal_line_editor_unit_macros.svh =====
// Assertion macros shared by the terminal line editor RTL.
// No dependencies; included by tle_datapath, which checks its own logic.
`ifndef TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH
`define TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH

// a holds in a cycle -> b holds in the same cycle
`define TLE_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) else $error(msg);

// a holds in a cycle -> b holds in the next cycle
`define TLE_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) else $error(msg);

`endif

// ===== hdl/tle_pkg.sv =====
// Package for the terminal line editor: codes, control word layout and the
// microcode table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

	localparam int unsigned LINE_MAX_DEF = 64;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned LEN_W = 7;
	localparam int unsigned ACT_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned STEP_W = 5;

	localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'd126;

	localparam logic [LEN_W-1:0] RST_LINE_LIMIT = 7'd40;
	localparam logic [CHAR_W-1:0] RST_ERASE = 8'd127;
	localparam logic [CHAR_W-1:0] RST_KILL = 8'd21;
	localparam logic [CHAR_W-1:0] RST_WERASE = 8'd23;
	localparam logic [CHAR_W-1:0] RST_EOF = 8'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KILL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WERASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EOF = 3'd4;

	typedef enum logic [ACT_W-1:0] {
		ACT_ECHO = 3'd0,
		ACT_ERASE = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_BEEP = 3'd3,
		ACT_WRAP = 3'd4,
		ACT_LINE_END = 3'd5,
		ACT_END_INPUT = 3'd6
	} act_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_INPUT,
		C_IS_NL,
		C_IS_EOF_EMPTY,
		C_IS_ERASE,
		C_IS_KILL,
		C_IS_WERASE,
		C_IS_PRINT,
		C_BELOW_LIM,
		C_CUR_ZERO,
		C_CUR_ONE,
		C_SPACE,
		C_NOT_SPACE
	} cond_t;

	typedef enum logic [1:0] {CHS_ZERO, CHS_INPUT, CHS_NL} chsel_t;
	typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_IF_ZERO} lastsel_t;
	typedef enum logic [1:0] {CUR_HOLD, CUR_CLEAR, CUR_DEC, CUR_INC} curop_t;
	typedef enum logic [1:0] {RD_NONE, RD_M1, RD_M2} rdsel_t;

	typedef struct packed {
		logic take_in;
		cond_t cond;
		logic [STEP_W-1:0] target;
		logic emit;
		act_t act;
		chsel_t chsel;
		lastsel_t lastsel;
		curop_t curop;
		logic mem_we;
		rdsel_t rdsel;
	} ctrl_t;

	typedef struct packed {
		logic go;
		logic no_input;
		logic is_nl;
		logic is_eof_empty;
		logic is_erase;
		logic is_kill;
		logic is_werase;
		logic is_print;
		logic below_lim;
		logic cur_zero;
		logic cur_one;
		logic rd_space;
	} stat_t;

	// program addresses
	localparam logic [STEP_W-1:0] S_IDLE = STEP_W'(0);
	localparam logic [STEP_W-1:0] S_TST_NL = STEP_W'(1);
	localparam logic [STEP_W-1:0] S_TST_EOF = STEP_W'(2);
	localparam logic [STEP_W-1:0] S_TST_ERASE = STEP_W'(3);
	localparam logic [STEP_W-1:0] S_TST_KILL = STEP_W'(4);
	localparam logic [STEP_W-1:0] S_TST_WE = STEP_W'(5);
	localparam logic [STEP_W-1:0] S_TST_PRINT = STEP_W'(6);
	localparam logic [STEP_W-1:0] S_BEEP = STEP_W'(7);
	localparam logic [STEP_W-1:0] S_NL = STEP_W'(8);
	localparam logic [STEP_W-1:0] S_EOF = STEP_W'(9);
	localparam logic [STEP_W-1:0] S_ERASE = STEP_W'(10);
	localparam logic [STEP_W-1:0] S_ERASE_GO = STEP_W'(11);
	localparam logic [STEP_W-1:0] S_KILL = STEP_W'(12);
	localparam logic [STEP_W-1:0] S_PRINT = STEP_W'(13);
	localparam logic [STEP_W-1:0] S_WRAP = STEP_W'(14);
	localparam logic [STEP_W-1:0] S_ECHO = STEP_W'(15);
	localparam logic [STEP_W-1:0] S_WE = STEP_W'(16);
	localparam logic [STEP_W-1:0] S_WE_SP_TST = STEP_W'(17);
	localparam logic [STEP_W-1:0] S_WE_SP = STEP_W'(18);
	localparam logic [STEP_W-1:0] S_WE_SP_RD = STEP_W'(19);
	localparam logic [STEP_W-1:0] S_WE_SP_CHK = STEP_W'(20);
	localparam logic [STEP_W-1:0] S_WE_WD = STEP_W'(21);
	localparam logic [STEP_W-1:0] S_WE_WD_CHK = STEP_W'(22);
	localparam logic [STEP_W-1:0] S_WE_WD_ERA = STEP_W'(23);
	localparam logic [STEP_W-1:0] S_WE_WD_LAST = STEP_W'(24);

	localparam ctrl_t CTRL_NOP = '{
		take_in: 1'b0, cond: C_NONE, target: S_IDLE, emit: 1'b0, act: ACT_ECHO,
		chsel: CHS_ZERO, lastsel: LAST_NO, curop: CUR_HOLD, mem_we: 1'b0,
		rdsel: RD_NONE
	};

	// Microcode ROM. A step jumps to target when its condition holds, else
	// steps on. Emitting steps hold until the output register is free.
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = CTRL_NOP;
		case (step)
			S_IDLE: begin
				w.take_in = 1'b1; w.cond = C_NO_INPUT; w.target = S_IDLE;
			end
			S_TST_NL: begin
				w.cond = C_IS_NL; w.target = S_NL;
			end
			S_TST_EOF: begin
				w.cond = C_IS_EOF_EMPTY; w.target = S_EOF;
			end
			S_TST_ERASE: begin
				w.cond = C_IS_ERASE; w.target = S_ERASE;
			end
			S_TST_KILL: begin
				w.cond = C_IS_KILL; w.target = S_KILL;
			end
			S_TST_WE: begin
				w.cond = C_IS_WERASE; w.target = S_WE;
			end
			S_TST_PRINT: begin
				w.cond = C_IS_PRINT; w.target = S_PRINT;
			end
			S_BEEP: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
				w.emit = 1'b1; w.act = ACT_BEEP; w.lastsel = LAST_YES;
			end
			S_NL: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.curop = CUR_CLEAR;
				w.emit = 1'b1; w.act = ACT_LINE_END; w.chsel = CHS_NL;
				w.lastsel = LAST_YES;
			end
			S_EOF: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
				w.emit = 1'b1; w.act = ACT_END_INPUT; w.lastsel = LAST_YES;
			end
			S_ERASE: begin
				w.cond = C_CUR_ZERO; w.target = S_IDLE;
			end
			S_ERASE_GO: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.curop = CUR_DEC;
				w.emit = 1'b1; w.act = ACT_ERASE; w.lastsel = LAST_YES;
			end
			S_KILL: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.curop = CUR_CLEAR;
				w.emit = 1'b1; w.act = ACT_CLEAR; w.lastsel = LAST_YES;
			end
			S_PRINT: begin
				w.cond = C_BELOW_LIM; w.target = S_ECHO;
			end
			S_WRAP: begin
				w.curop = CUR_CLEAR;
				w.emit = 1'b1; w.act = ACT_WRAP;
			end
			S_ECHO: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.curop = CUR_INC;
				w.mem_we = 1'b1;
				w.emit = 1'b1; w.act = ACT_ECHO; w.chsel = CHS_INPUT;
				w.lastsel = LAST_YES;
			end
			S_WE: begin
				w.cond = C_CUR_ZERO; w.target = S_IDLE; w.rdsel = RD_M1;
			end
			S_WE_SP_TST: begin
				w.cond = C_NOT_SPACE; w.target = S_WE_WD;
			end
			// a trailing space always has another character, or nothing, below it
			S_WE_SP: begin
				w.curop = CUR_DEC;
				w.emit = 1'b1; w.act = ACT_ERASE; w.lastsel = LAST_IF_ZERO;
			end
			S_WE_SP_RD: begin
				w.cond = C_CUR_ZERO; w.target = S_IDLE; w.rdsel = RD_M1;
			end
			S_WE_SP_CHK: begin
				w.cond = C_SPACE; w.target = S_WE_SP;
			end
			// word run: look one below before erasing to know if it ends
			S_WE_WD: begin
				w.cond = C_CUR_ONE; w.target = S_WE_WD_LAST; w.rdsel = RD_M2;
			end
			S_WE_WD_CHK: begin
				w.cond = C_SPACE; w.target = S_WE_WD_LAST;
			end
			S_WE_WD_ERA: begin
				w.cond = C_ALWAYS; w.target = S_WE_WD; w.curop = CUR_DEC;
				w.emit = 1'b1; w.act = ACT_ERASE;
			end
			S_WE_WD_LAST: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.curop = CUR_DEC;
				w.emit = 1'b1; w.act = ACT_ERASE; w.lastsel = LAST_YES;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tle_if.sv =====
// Channel interfaces of the terminal line editor: key bytes in, echo
// actions out. Widths follow the package constants.
`timescale 1ns / 1ps
`default_nettype none

interface tle_char_if;
	logic valid;
	logic ready;
	logic [tle_pkg::CHAR_W-1:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface tle_act_if;
	logic valid;
	logic ready;
	logic [tle_pkg::ACT_W-1:0] action;
	logic [tle_pkg::CHAR_W-1:0] char_out;
	logic [tle_pkg::LEN_W-1:0] line_length;
	logic last;

	modport source (output valid, output action, output char_out, output line_length,
		output last, input ready);
	modport sink (input valid, input action, input char_out, input line_length,
		input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/tle_line_mem.sv =====
// Line store: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tle_line_mem #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [7:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tle_sequencer.sv =====
// Step counter and microcode fetch with conditional jumps.
// Depends on tle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tle_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	input wire tle_pkg::stat_t stat,
	output tle_pkg::ctrl_t ctrl
);
	import tle_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic hit;

	always_comb begin
		ctrl = ucode(step_q);
	end

	always_comb begin
		case (ctrl.cond)
			C_NONE: hit = 1'b0;
			C_ALWAYS: hit = 1'b1;
			C_NO_INPUT: hit = stat.no_input;
			C_IS_NL: hit = stat.is_nl;
			C_IS_EOF_EMPTY: hit = stat.is_eof_empty;
			C_IS_ERASE: hit = stat.is_erase;
			C_IS_KILL: hit = stat.is_kill;
			C_IS_WERASE: hit = stat.is_werase;
			C_IS_PRINT: hit = stat.is_print;
			C_BELOW_LIM: hit = stat.below_lim;
			C_CUR_ZERO: hit = stat.cur_zero;
			C_CUR_ONE: hit = stat.cur_one;
			C_SPACE: hit = stat.rd_space;
			C_NOT_SPACE: hit = !stat.rd_space;
			default: hit = 1'b1;
		endcase
	end

	always_comb begin
		if (!stat.go) begin
			step_d = step_q;
		end else if (hit) begin
			step_d = ctrl.target;
		end else begin
			step_d = step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tle_datapath.sv =====
// Datapath: config registers, key latch, cursor, byte decode, memory
// addressing and the output register. Depends on tle_pkg, tle_if, macros.
`timescale 1ns / 1ps
`default_nettype none

`include "terminal_line_editor_unit_macros.svh"

module tle_datapath #(
	parameter int unsigned LINE_MAX = tle_pkg::LINE_MAX_DEF,
	localparam int unsigned AW = $clog2(LINE_MAX)
) (
	input wire logic clk,
	input wire logic arst_n,
	tle_char_if.sink key,
	tle_act_if.source echo,
	input wire logic cfg_we,
	input wire logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tle_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire tle_pkg::ctrl_t ctrl,
	output tle_pkg::stat_t stat,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0] mem_wdata,
	output logic mem_re,
	output logic [AW-1:0] mem_raddr,
	input wire logic [7:0] mem_rdata
);
	import tle_pkg::*;

	localparam int unsigned CW = $clog2(LINE_MAX + 1);
	localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;

	logic [LEN_W-1:0] lim_q;
	logic [CHAR_W-1:0] erase_q, kill_q, werase_q, eof_q;
	logic [CHAR_W-1:0] char_q;
	logic [CW-1:0] cur_q, cursor_d, cur_m1, cur_m2;
	logic [LW-1:0] lim_eff, cur_ext, cur_d_ext;
	logic slot_free, go, load, last_d;
	logic [CHAR_W-1:0] ch_d;

	logic ov_q;
	act_t act_q;
	logic [CHAR_W-1:0] ch_q;
	logic [LEN_W-1:0] len_q;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= RST_LINE_LIMIT;
			erase_q <= RST_ERASE;
			kill_q <= RST_KILL;
			werase_q <= RST_WERASE;
			eof_q <= RST_EOF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LIMIT: lim_q <= cfg_data[LEN_W-1:0];
				REG_ERASE: erase_q <= cfg_data;
				REG_KILL: kill_q <= cfg_data;
				REG_WERASE: werase_q <= cfg_data;
				REG_EOF: eof_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key.ready = ctrl.take_in;

	always_ff @(posedge clk) begin
		if (ctrl.take_in && key.valid) begin
			char_q <= key.char_in;
		end
	end

	// zero acts as one, above the store depth acts as the depth
	always_comb begin
		if (lim_q == '0) begin
			lim_eff = LW'(1);
		end else if (LW'(lim_q) > LW'(LINE_MAX)) begin
			lim_eff = LW'(LINE_MAX);
		end else begin
			lim_eff = LW'(lim_q);
		end
	end

	assign cur_ext = LW'(cur_q);
	assign cur_m1 = cur_q - CW'(1);
	assign cur_m2 = cur_q - CW'(2);

	always_comb begin
		case (ctrl.curop)
			CUR_HOLD: cursor_d = cur_q;
			CUR_CLEAR: cursor_d = '0;
			CUR_DEC: cursor_d = cur_m1;
			CUR_INC: cursor_d = cur_q + CW'(1);
			default: cursor_d = cur_q;
		endcase
	end
	assign cur_d_ext = LW'(cursor_d);

	assign slot_free = !ov_q || echo.ready;
	assign go = !ctrl.emit || slot_free;
	assign load = ctrl.emit && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (go) begin
			cur_q <= cursor_d;
		end
	end

	always_comb begin
		stat.go = go;
		stat.no_input = !key.valid;
		stat.is_nl = char_q == CH_NL;
		stat.is_eof_empty = (char_q == eof_q) && (cur_q == '0);
		stat.is_erase = char_q == erase_q;
		stat.is_kill = char_q == kill_q;
		stat.is_werase = char_q == werase_q;
		stat.is_print = (char_q >= CH_SPACE) && (char_q <= CH_TILDE);
		stat.below_lim = cur_ext < lim_eff;
		stat.cur_zero = cur_q == '0;
		stat.cur_one = cur_q == CW'(1);
		stat.rd_space = mem_rdata == CH_SPACE;
	end

	assign mem_we = ctrl.mem_we && go;
	assign mem_waddr = cur_q[AW-1:0];
	assign mem_wdata = char_q;
	assign mem_re = ctrl.rdsel != RD_NONE;
	assign mem_raddr = (ctrl.rdsel == RD_M2) ? cur_m2[AW-1:0] : cur_m1[AW-1:0];

	always_comb begin
		case (ctrl.chsel)
			CHS_ZERO: ch_d = '0;
			CHS_INPUT: ch_d = char_q;
			CHS_NL: ch_d = CH_NL;
			default: ch_d = '0;
		endcase
	end

	always_comb begin
		case (ctrl.lastsel)
			LAST_NO: last_d = 1'b0;
			LAST_YES: last_d = 1'b1;
			LAST_IF_ZERO: last_d = cursor_d == '0;
			default: last_d = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (echo.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			act_q <= ctrl.act;
			ch_q <= ch_d;
			len_q <= cur_d_ext[LEN_W-1:0];
			last_q <= last_d;
		end
	end

	assign echo.valid = ov_q;
	assign echo.action = ACT_W'(act_q);
	assign echo.char_out = ch_q;
	assign echo.line_length = len_q;
	assign echo.last = last_q;

	`TLE_ASSERT_IMPLY(a_cur_range, clk, arst_n, 1'b1, cur_q <= CW'(LINE_MAX), "cursor above depth")
	`TLE_ASSERT_IMPLY(a_wr_range, clk, arst_n, mem_we, cur_q < CW'(LINE_MAX), "write past end of line")
	`TLE_ASSERT_IMPLY(a_take_quiet, clk, arst_n, ctrl.take_in, !ctrl.emit && !mem_we && cursor_d == cur_q, "side effect while taking a key")
	`TLE_ASSERT_NEXT(a_load_shows, clk, arst_n, load, ov_q, "loaded action not shown")

endmodule

`default_nettype wire

// ===== hdl/terminal_line_editor_unit.sv =====
// Terminal line editor: one key byte in, a run of echo actions out. Top level,
// built on tle_pkg, tle_if, tle_sequencer, tle_datapath and tle_line_mem.
`timescale 1ns / 1ps
`default_nettype none

// Each key byte runs a short microcode program, one control word per cycle
// while no emitting step waits. A key is taken in the idle step; decoding
// walks a chain of tests, one a cycle: a newline is answered after the first
// test, a printable byte after all of them (with a wrap step first on a full
// line), a beep when all fail. Word erase walks the line store through its
// single registered read port, reading below the cursor before each removal.
// Results leave through an output register; an emitting step waits while a
// result is still pending there, and the next key can be taken while the last
// result of the previous one waits. The line store is not cleared at reset;
// only characters below the cursor are ever used.
module terminal_line_editor_unit #(
	parameter int unsigned LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tle_char_if.sink key,
	tle_act_if.source echo,
	input wire logic cfg_we,
	input wire logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tle_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tle_pkg::*;

	localparam int unsigned AW = $clog2(LINE_MAX);

	ctrl_t ctrl;
	stat_t stat;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;

	tle_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.ctrl(ctrl)
	);

	tle_datapath #(.LINE_MAX(LINE_MAX)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.key(key),
		.echo(echo),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.ctrl(ctrl),
		.stat(stat),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	tle_line_mem #(.DEPTH(LINE_MAX)) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for terminal_line_editor_unit: directed key table, then random
// typing under several register settings, with random stalls on both channels.
// Depends on tle_pkg, tle_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
	import tle_pkg::*;

	localparam int unsigned LINE_MAX = LINE_MAX_DEF;

	typedef struct {
		act_t action;
		logic [CHAR_W-1:0] ch;
		logic [LEN_W-1:0] len;
		logic last;
	} echo_t;

	typedef enum {ROW_KEY, ROW_KEY_TYPED, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CHAR_W-1:0] val;
		logic [CFG_IDX_W-1:0] idx;
		act_t act;
		logic [CHAR_W-1:0] ch;
		logic [LEN_W-1:0] len;
	} plan_row_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] limit;
		logic [CHAR_W-1:0] erase;
		logic [CHAR_W-1:0] kill;
		logic [CHAR_W-1:0] werase;
		logic [CHAR_W-1:0] eof;
		bit long_word;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tle_char_if key_ch ();
	tle_act_if echo_ch ();

	terminal_line_editor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_ch),
		.echo(echo_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// line model
	logic [CHAR_W-1:0] held_chars [LINE_MAX];
	int unsigned cur;
	logic [LEN_W-1:0] lim_q;
	logic [CHAR_W-1:0] erase_q, kill_q, werase_q, eof_q;

	echo_t pending_actions [$];

	int err_count = 0;
	int n_keys = 0;
	int n_actions = 0;
	int n_cfg = 0;
	int n_wraps = 0;
	int longest_run = 0;
	bit calm_key = 1'b0;
	bit calm_echo = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("%0t timeout, %0d actions still expected", $time, pending_actions.size());
		$display("terminal_line_editor_unit test failed");
		$finish;
	end

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	function automatic void emit_action(input act_t a, input logic [CHAR_W-1:0] ch,
		input int unsigned len);
		echo_t e;
		e.action = a;
		e.ch = ch;
		e.len = LEN_W'(len);
		e.last = 1'b0;
		pending_actions.push_back(e);
	endfunction

	// Expected echo actions for one key; updates the line model.
	function automatic void edit_line(input logic [CHAR_W-1:0] c);
		int unsigned lim;
		int start;
		start = pending_actions.size();
		lim = 32'(lim_q);
		if (lim == 0)
			lim = 1;
		if (lim > LINE_MAX)
			lim = LINE_MAX;
		if (c == CH_NL) begin
			cur = 0;
			emit_action(ACT_LINE_END, CH_NL, 0);
		end else if (c == eof_q && cur == 0) begin
			emit_action(ACT_END_INPUT, 8'd0, 0);
		end else if (c == erase_q) begin
			if (cur > 0) begin
				cur--;
				emit_action(ACT_ERASE, 8'd0, cur);
			end
		end else if (c == kill_q) begin
			cur = 0;
			emit_action(ACT_CLEAR, 8'd0, 0);
		end else if (c == werase_q) begin
			while (cur > 0 && held_chars[cur-1] == CH_SPACE) begin
				cur--;
				emit_action(ACT_ERASE, 8'd0, cur);
			end
			while (cur > 0 && held_chars[cur-1] != CH_SPACE) begin
				cur--;
				emit_action(ACT_ERASE, 8'd0, cur);
			end
		end else if (c >= CH_SPACE && c <= CH_TILDE) begin
			if (cur >= lim) begin
				cur = 0;
				n_wraps++;
				emit_action(ACT_WRAP, 8'd0, 0);
			end
			held_chars[cur] = c;
			cur++;
			emit_action(ACT_ECHO, c, cur);
		end else begin
			emit_action(ACT_BEEP, 8'd0, cur);
		end
		if (pending_actions.size() > start)
			pending_actions[pending_actions.size()-1].last = 1'b1;
		if (pending_actions.size() - start > longest_run)
			longest_run = pending_actions.size() - start;
	endfunction

	// Mostly typing and editing with the current codes, some raw bytes.
	function automatic logic [CHAR_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return CHAR_W'($urandom_range(33, 126));
		if (r < 60)
			return CH_SPACE;
		if (r < 68)
			return erase_q;
		if (r < 74)
			return werase_q;
		if (r < 77)
			return kill_q;
		if (r < 81)
			return CH_NL;
		if (r < 85)
			return eof_q;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	function automatic plan_row_t key_row(input logic [CHAR_W-1:0] c);
		plan_row_t r;
		r = '{ROW_KEY, c, REG_LINE_LIMIT, ACT_ECHO, 8'd0, 7'd0};
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [CHAR_W-1:0] c, input act_t a,
		input logic [CHAR_W-1:0] ch, input logic [LEN_W-1:0] len);
		plan_row_t r;
		r = '{ROW_KEY_TYPED, c, REG_LINE_LIMIT, a, ch, len};
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] v);
		plan_row_t r;
		r = '{ROW_CFG, v, idx, ACT_ECHO, 8'd0, 7'd0};
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_key(input logic [CHAR_W-1:0] c, input bit typed, input echo_t want);
		int gap;
		int start;
		cfg_we = 1'b0;
		gap = draw_wait(calm_key);
		if (gap > 0) begin
			key_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		key_ch.valid = 1'b1;
		key_ch.char_in = c;
		@(posedge clk);
		while (!key_ch.ready)
			@(posedge clk);
		start = pending_actions.size();
		edit_line(c);
		if (typed) begin
			while (pending_actions.size() > start)
				void'(pending_actions.pop_back());
			pending_actions.push_back(want);
		end
		n_keys++;
		if ($urandom_range(0, 15) == 0)
			calm_key = !calm_key;
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		case (idx)
			REG_LINE_LIMIT: lim_q = v[LEN_W-1:0];
			REG_ERASE: erase_q = v;
			REG_KILL: kill_q = v;
			REG_WERASE: werase_q = v;
			REG_EOF: eof_q = v;
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
	endtask

	// Wait for all expected actions, then give a key with no action time to finish.
	task automatic settle();
		int spin;
		spin = 0;
		key_ch.valid = 1'b0;
		cfg_we = 1'b0;
		while (pending_actions.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		if (pending_actions.size() != 0) begin
			$display("%0t %0d expected actions never arrived", $time, pending_actions.size());
			err_count++;
			pending_actions.delete();
		end
		repeat (250) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_echo
		echo_t got;
		echo_t want;
		if (arst_n && echo_ch.valid && echo_ch.ready) begin
			got.action = act_t'(echo_ch.action);
			got.ch = echo_ch.char_out;
			got.len = echo_ch.line_length;
			got.last = echo_ch.last;
			n_actions++;
			if (pending_actions.size() == 0) begin
				$display("%0t unexpected action: act %0d ch %0d len %0d last %0b", $time,
					got.action, got.ch, got.len, got.last);
				err_count++;
			end else begin
				want = pending_actions.pop_front();
				if (got.action !== want.action || got.ch !== want.ch ||
					got.len !== want.len || got.last !== want.last) begin
					$display("%0t mismatch: expected act %0d ch %0d len %0d last %0b, got act %0d ch %0d len %0d last %0b",
						$time, want.action, want.ch, want.len, want.last,
						got.action, got.ch, got.len, got.last);
					err_count++;
				end
			end
		end
	end

	initial begin : echo_sink
		int hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = draw_wait(calm_echo);
			if (hold > 0) begin
				echo_ch.ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			echo_ch.ready = 1'b1;
			@(posedge clk);
			while (!echo_ch.valid)
				@(posedge clk);
			if ($urandom_range(0, 15) == 0)
				calm_echo = !calm_echo;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		phase_t phases [$];
		echo_t want;
		bit settled;

		key_ch.valid = 1'b0;
		key_ch.char_in = '0;
		echo_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		want = '{ACT_ECHO, 8'd0, 7'd0, 1'b0};

		cur = 0;
		lim_q = RST_LINE_LIMIT;
		erase_q = RST_ERASE;
		kill_q = RST_KILL;
		werase_q = RST_WERASE;
		eof_q = RST_EOF;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan = '{
			typed_row(RST_EOF, ACT_END_INPUT, 8'd0, 7'd0),
			key_row(RST_ERASE),                      // erase on empty line: nothing
			key_row(RST_WERASE),                     // word erase on empty line: nothing
			typed_row(RST_KILL, ACT_CLEAR, 8'd0, 7'd0),
			typed_row(8'd0, ACT_BEEP, 8'd0, 7'd0),
			typed_row(8'd255, ACT_BEEP, 8'd0, 7'd0),
			typed_row(CH_SPACE, ACT_ECHO, CH_SPACE, 7'd1),
			typed_row(CH_TILDE, ACT_ECHO, CH_TILDE, 7'd2),
			typed_row(RST_EOF, ACT_BEEP, 8'd0, 7'd2),   // EOF with text held
			key_row("a"),
			key_row(CH_SPACE),
			key_row(CH_SPACE),
			key_row(RST_WERASE),                     // spaces, then the word
			key_row(RST_ERASE),
			typed_row(CH_NL, ACT_LINE_END, CH_NL, 7'd0),
			reg_row(REG_LINE_LIMIT, 8'd1),
			typed_row("x", ACT_ECHO, "x", 7'd1),
			key_row("y"),
			reg_row(REG_LINE_LIMIT, 8'd0),           // zero limit behaves as one
			key_row("z"),
			reg_row(REG_EOF, "q"),
			reg_row(REG_ERASE, CH_NL),
			reg_row(REG_KILL, 8'd255),
			reg_row(REG_WERASE, 8'd0),
			key_row("q"),                            // printable EOF on a held line
			typed_row(CH_NL, ACT_LINE_END, CH_NL, 7'd0),
			typed_row("q", ACT_END_INPUT, 8'd0, 7'd0),
			reg_row(REG_LINE_LIMIT, 8'hFF),
			reg_row(REG_EOF, 8'd255),                // EOF shares the kill code
			typed_row(8'd255, ACT_END_INPUT, 8'd0, 7'd0),
			typed_row("m", ACT_ECHO, "m", 7'd1),
			typed_row(8'd255, ACT_CLEAR, 8'd0, 7'd0),
			typed_row(RST_ERASE, ACT_BEEP, 8'd0, 7'd0),
			key_row(8'd0)
		};

		settled = 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!settled)
					settle();
				settled = 1'b1;
				set_reg(plan[i].idx, plan[i].val);
			end else begin
				settled = 1'b0;
				want = '{plan[i].act, plan[i].ch, plan[i].len, 1'b1};
				send_key(plan[i].val, plan[i].kind == ROW_KEY_TYPED, want);
			end
		end

		phases = '{
			'{8'd40, RST_ERASE, RST_KILL, RST_WERASE, RST_EOF, 1'b0},
			'{8'd64, 8'd8, 8'd24, 8'd23, 8'd4, 1'b1},
			'{8'd8, 8'd0, 8'd255, 8'd127, 8'd126, 1'b0},
			'{8'd1, CH_SPACE, CH_NL, 8'd21, 8'd23, 1'b0},
			'{8'hE4, RST_ERASE, RST_KILL, RST_WERASE, RST_EOF, 1'b0}
		};

		foreach (phases[p]) begin
			settle();
			set_reg(REG_LINE_LIMIT, phases[p].limit);
			set_reg(REG_ERASE, phases[p].erase);
			set_reg(REG_KILL, phases[p].kill);
			set_reg(REG_WERASE, phases[p].werase);
			set_reg(REG_EOF, phases[p].eof);
			// full line of one word, then a word erase of all of it
			if (phases[p].long_word) begin
				send_key(CH_NL, 1'b0, want);
				repeat (LINE_MAX)
					send_key(CHAR_W'($urandom_range(33, 126)), 1'b0, want);
				send_key(werase_q, 1'b0, want);
			end
			repeat (6)
				send_key(pick_key(), 1'b0, want);
		end

		settle();
		$display("run covered %0d keys, %0d echo actions, %0d register writes", n_keys,
			n_actions, n_cfg);
		$display("line wraps seen %0d, longest action run for one key %0d", n_wraps,
			longest_run);
		if (err_count == 0)
			$display("terminal_line_editor_unit test passed");
		else
			$display("terminal_line_editor_unit test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tle_pkg.sv
hdl/tle_if.sv
hdl/tle_line_mem.sv
hdl/tle_sequencer.sv
hdl/tle_datapath.sv
hdl/terminal_line_editor_unit.sv
tb/tb.sv
